// File: hdl/quaternion_point_rotate_pivot_top_assert.svh
// Assertion macros for the quaternion point rotation block.
// Used by the top level only; needs no other file.
`ifndef QUATERNION_POINT_ROTATE_PIVOT_TOP_ASSERT_SVH
`define QUATERNION_POINT_ROTATE_PIVOT_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define QPRP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the next cycle.
`define QPRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: hdl/qprp_pkg.sv
// Package for the quaternion point rotation block: widths, register
// indexes and the divider transfer types. Depends on nothing.
`timescale 1ns / 1ps

package qprp_pkg;

   localparam int QUAT_W  = 16;
   localparam int PT_W    = 24;
   localparam int V_W     = PT_W + 1;
   localparam int PV_W    = V_W + QUAT_W;
   localparam int T_W     = PV_W + 2;
   localparam int QT_W    = T_W + QUAT_W;
   localparam int R_W     = QT_W + 3;
   localparam int NORM_W  = 2 * QUAT_W + 1;
   localparam int DEN_W   = NORM_W + 1;
   localparam int REM_W   = R_W + 2;
   localparam int QUOT_W  = 27;
   localparam int SUM_W   = QUOT_W + 2;
   localparam int LATENCY = 7 + QUOT_W;
   localparam int ADDR_W  = 5;

   localparam logic [2:0] REG_QUAT_X  = 3'd0;
   localparam logic [2:0] REG_QUAT_Y  = 3'd1;
   localparam logic [2:0] REG_QUAT_Z  = 3'd2;
   localparam logic [2:0] REG_QUAT_W  = 3'd3;
   localparam logic [2:0] REG_PIVOT_X = 3'd4;
   localparam logic [2:0] REG_PIVOT_Y = 3'd5;
   localparam logic [2:0] REG_PIVOT_Z = 3'd6;

   localparam logic [QUAT_W-1:0] QUAT_W_RESET = 16'd8192;

   typedef struct packed {
      logic             valid;
      logic             neg;
      logic [REM_W-1:0] num;
   } div_in_type;

   typedef struct packed {
      logic              valid;
      logic              neg;
      logic [QUOT_W-1:0] quo;
   } div_out_type;

endpackage

// File: hdl/qprp_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on qprp_pkg for widths and the transfer structs.
`timescale 1ns / 1ps

module qprp_divider import qprp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  div_in_type        div_in,
   input  logic [DEN_W-1:0]  den,
   output div_out_type       div_out
);

   logic [REM_W-1:0]  rem_ff [0:QUOT_W];
   logic [QUOT_W-1:0] quo_ff [0:QUOT_W];
   logic              neg_ff [0:QUOT_W];
   logic              vld_ff [0:QUOT_W];

   // Entry register.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= div_in.valid;
      end
      rem_ff[0] <= div_in.num;
      quo_ff[0] <= '0;
      neg_ff[0] <= div_in.neg;
   end

   // Each stage tries the shifted divisor for one quotient bit.
   for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
      localparam int BIT = QUOT_W - 1 - k;
      logic [REM_W-1:0] shifted;
      logic [REM_W:0]   trial;
      logic [QUOT_W-1:0] quo_in;

      assign shifted = REM_W'(den) << BIT;
      assign trial   = {1'b0, rem_ff[k]} - {1'b0, shifted};

      always_comb begin
         quo_in      = quo_ff[k];
         quo_in[BIT] = ~trial[REM_W];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
         rem_ff[k+1] <= trial[REM_W] ? rem_ff[k] : trial[REM_W-1:0];
         quo_ff[k+1] <= quo_in;
         neg_ff[k+1] <= neg_ff[k];
      end
   end

   assign div_out.valid = vld_ff[QUOT_W];
   assign div_out.neg   = neg_ff[QUOT_W];
   assign div_out.quo   = quo_ff[QUOT_W];

endmodule

// File: hdl/quaternion_point_rotate_pivot_top.sv
// Top level of the quaternion point rotation block: registers, product
// pipeline and output saturation. Depends on qprp_pkg, qprp_divider and the assertion header.
//
// Usage. The quaternion (Q2.13) and pivot (Q15.8) are written through the
// APB-style csr_ port while no points are in flight; pready is always high
// and reads return the stored register bits. A point is transferred in at
// each rising edge with start high and busy low; busy is never raised, so
// one point may enter every cycle. Each point gives one result on the rsp_
// ports, shown for one cycle with rsp_valid, after its transfer passes
// the subtraction and quaternion product registers, the divider entry
// register that takes the rounded dividend, 27 divider stages (one
// quotient bit each) and one output register. Throughput is one point
// per cycle. A zero quaternion gives the pivot and raises rsp_zero_norm.
// The receiver cannot stall, so results are never held.
// Reset restores the identity quaternion and a zero pivot and empties the
// pipeline; points in flight at reset are dropped.
`timescale 1ns / 1ps

module quaternion_point_rotate_pivot_top import qprp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [PT_W-1:0]   req_point_x,
   input  logic signed [PT_W-1:0]   req_point_y,
   input  logic signed [PT_W-1:0]   req_point_z,
   output logic                     rsp_valid,
   output logic signed [PT_W-1:0]   rsp_rotated_x,
   output logic signed [PT_W-1:0]   rsp_rotated_y,
   output logic signed [PT_W-1:0]   rsp_rotated_z,
   output logic                     rsp_zero_norm,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [ADDR_W-1:0]        csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

`include "quaternion_point_rotate_pivot_top_assert.svh"

   logic signed [QUAT_W-1:0] quat_ff [0:3];
   logic signed [PT_W-1:0]   pivot_ff [0:2];
   logic [2:0]               reg_idx;
   logic                     csr_wr;

   assign busy       = 1'b0;
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         quat_ff[0]  <= '0;
         quat_ff[1]  <= '0;
         quat_ff[2]  <= '0;
         quat_ff[3]  <= QUAT_W_RESET;
         pivot_ff[0] <= '0;
         pivot_ff[1] <= '0;
         pivot_ff[2] <= '0;
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_QUAT_X:  quat_ff[0]  <= csr_pwdata[QUAT_W-1:0];
            REG_QUAT_Y:  quat_ff[1]  <= csr_pwdata[QUAT_W-1:0];
            REG_QUAT_Z:  quat_ff[2]  <= csr_pwdata[QUAT_W-1:0];
            REG_QUAT_W:  quat_ff[3]  <= csr_pwdata[QUAT_W-1:0];
            REG_PIVOT_X: pivot_ff[0] <= csr_pwdata[PT_W-1:0];
            REG_PIVOT_Y: pivot_ff[1] <= csr_pwdata[PT_W-1:0];
            REG_PIVOT_Z: pivot_ff[2] <= csr_pwdata[PT_W-1:0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (reg_idx)
         REG_QUAT_X:  csr_prdata = {16'd0, quat_ff[0]};
         REG_QUAT_Y:  csr_prdata = {16'd0, quat_ff[1]};
         REG_QUAT_Z:  csr_prdata = {16'd0, quat_ff[2]};
         REG_QUAT_W:  csr_prdata = {16'd0, quat_ff[3]};
         REG_PIVOT_X: csr_prdata = {8'd0, pivot_ff[0]};
         REG_PIVOT_Y: csr_prdata = {8'd0, pivot_ff[1]};
         REG_PIVOT_Z: csr_prdata = {8'd0, pivot_ff[2]};
         default:     csr_prdata = '0;
      endcase
   end

   // Squared norm follows the registers; the user must change it only while idle (not enforced).
   logic [NORM_W-1:0] norm_ff;
   logic [NORM_W-1:0] norm_in;
   logic              zero_ff;

   always_comb begin
      norm_in = '0;
      for (int j = 0; j < 4; j++) begin
         norm_in = norm_in
                 + NORM_W'($unsigned(32'(quat_ff[j]) * 32'(quat_ff[j])));
      end
   end

   always_ff @(posedge clock) begin
      norm_ff <= norm_in;
      zero_ff <= (norm_in == '0);
   end

   // Stage 0: point minus pivot.
   logic                   s0_vld_ff;
   logic signed [V_W-1:0]  v_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= start & ~busy;
      end
      v_ff[0] <= V_W'(req_point_x) - V_W'(pivot_ff[0]);
      v_ff[1] <= V_W'(req_point_y) - V_W'(pivot_ff[1]);
      v_ff[2] <= V_W'(req_point_z) - V_W'(pivot_ff[2]);
   end

   // Stage 1: products of vector and quaternion components.
   logic                   s1_vld_ff;
   logic signed [PV_W-1:0] pv_ff [0:2][0:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s0_vld_ff;
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 4; j++) begin
            pv_ff[i][j] <= PV_W'(v_ff[i] * quat_ff[j]);
         end
      end
   end

   // Stage 2: t = v * conj(q).
   logic                  s2_vld_ff;
   logic signed [T_W-1:0] t_ff [0:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      t_ff[0] <= T_W'(pv_ff[0][3]) + T_W'(pv_ff[2][1]) - T_W'(pv_ff[1][2]);
      t_ff[1] <= T_W'(pv_ff[1][3]) + T_W'(pv_ff[0][2]) - T_W'(pv_ff[2][0]);
      t_ff[2] <= T_W'(pv_ff[2][3]) + T_W'(pv_ff[1][0]) - T_W'(pv_ff[0][1]);
      t_ff[3] <= T_W'(pv_ff[0][0]) + T_W'(pv_ff[1][1]) + T_W'(pv_ff[2][2]);
   end

   // Stage 3: products of quaternion and t components.
   logic                   s3_vld_ff;
   logic signed [QT_W-1:0] qt_ff [0:3][0:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
      for (int j = 0; j < 4; j++) begin
         for (int k = 0; k < 4; k++) begin
            qt_ff[j][k] <= QT_W'(quat_ff[j] * t_ff[k]);
         end
      end
   end

   // Stage 4: vector part of q * t.
   logic                  s4_vld_ff;
   logic signed [R_W-1:0] r_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
      end
      r_ff[0] <= R_W'(qt_ff[3][0]) + R_W'(qt_ff[0][3]) + R_W'(qt_ff[1][2])
               - R_W'(qt_ff[2][1]);
      r_ff[1] <= R_W'(qt_ff[3][1]) + R_W'(qt_ff[1][3]) + R_W'(qt_ff[2][0])
               - R_W'(qt_ff[0][2]);
      r_ff[2] <= R_W'(qt_ff[3][2]) + R_W'(qt_ff[2][3]) + R_W'(qt_ff[0][1])
               - R_W'(qt_ff[1][0]);
   end

   // Rounded division: quotient of (2|r| + d) by 2d, sign applied after.
   logic [DEN_W-1:0] den;
   div_in_type       div_in  [0:2];
   div_out_type      div_out [0:2];

   assign den = {norm_ff, 1'b0};

   for (genvar c = 0; c < 3; c++) begin : g_axis
      logic [R_W-1:0] mag;

      assign mag = r_ff[c][R_W-1] ? R_W'(-r_ff[c]) : R_W'(r_ff[c]);
      assign div_in[c].valid = s4_vld_ff;
      assign div_in[c].neg   = r_ff[c][R_W-1];
      assign div_in[c].num   = {1'b0, mag, 1'b0} + REM_W'(norm_ff);

      qprp_divider u_div (
         .clock   (clock),
         .reset   (reset),
         .div_in  (div_in[c]),
         .den     (den),
         .div_out (div_out[c])
      );
   end

   // Output: add the pivot back and saturate; a zero norm gives the pivot.
   logic signed [PT_W-1:0] rot_in [0:2];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic signed [SUM_W-1:0] quo_s;
         logic signed [SUM_W-1:0] sum;
         quo_s = div_out[c].neg ? -$signed({2'b00, div_out[c].quo})
                                :  $signed({2'b00, div_out[c].quo});
         sum   = quo_s + SUM_W'(pivot_ff[c]);
         if (zero_ff) begin
            rot_in[c] = pivot_ff[c];
         end else if (sum > SUM_W'(signed'(24'sh7FFFFF))) begin
            rot_in[c] = 24'sh7FFFFF;
         end else if (sum < SUM_W'(signed'(-24'sh800000))) begin
            rot_in[c] = -24'sh800000;
         end else begin
            rot_in[c] = sum[PT_W-1:0];
         end
      end
   end

   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_out[0].valid;
      end
      rsp_rotated_x <= rot_in[0];
      rsp_rotated_y <= rot_in[1];
      rsp_rotated_z <= rot_in[2];
      rsp_zero_norm <= zero_ff;
   end

   assign rsp_valid = rsp_valid_ff;

   // A result appears only for a point transferred a fixed latency earlier.
   `QPRP_ASSERT_IMPL(a_latency, clock, reset, rsp_valid, $past(start & ~busy, LATENCY))
   // The three axis dividers stay in step.
   `QPRP_ASSERT_IMPL(a_axes, clock, reset, div_out[0].valid,
                     div_out[1].valid && div_out[2].valid)
   // A zero quaternion flag gives the pivot x and z coordinates at the output.
   `QPRP_ASSERT_IMPL(a_zero, clock, reset, rsp_valid && rsp_zero_norm,
                     rsp_rotated_x == pivot_ff[0] && rsp_rotated_z == pivot_ff[2])

endmodule
